### design/lce_pkg.sv
// Shared constants for the Game of Life engine: sizes, operation codes and register map.
package lce_pkg;

    // Default board storage limits.
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // Widths of the configuration registers and the APB port.
    localparam int CFG_W   = 7;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Operation codes carried by an input item.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WRAP   = 2'd2;

    // Rule B3/S23 neighbor counts.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

### design/lce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; a read of the written entry returns old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/lce_row_rule.sv
// One row of B3/S23 update lanes: new row from the rows above, at and below it.
module lce_row_rule #(
    parameter int MAX_WIDTH = lce_pkg::MAX_WIDTH
) (
    input  logic [MAX_WIDTH-1:0]           i_up,
    input  logic [MAX_WIDTH-1:0]           i_mid,
    input  logic [MAX_WIDTH-1:0]           i_down,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_eff_width,
    input  logic                           i_wrap,
    output logic [MAX_WIDTH-1:0]           o_next
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH+1);

    logic [CW-1:0]        last_col;
    logic [MAX_WIDTH-1:0] rows [3];
    logic [2:0]           first_bit;
    logic [2:0]           last_bit;

    // The last column in use and the edge bits that wrapping brings in.
    assign last_col = CW'(i_eff_width - EW'(1));
    assign rows[0]  = i_up;
    assign rows[1]  = i_mid;
    assign rows[2]  = i_down;

    for (genvar r = 0; r < 3; r++) begin : g_edge
        assign first_bit[r] = i_wrap & rows[r][0];
        assign last_bit[r]  = i_wrap & rows[r][last_col];
    end

    // One lane per column: count the eight neighbors and apply the rule.
    for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_lane
        logic [2:0] left;
        logic [2:0] right;
        logic [3:0] count;
        logic       alive;

        for (genvar r = 0; r < 3; r++) begin : g_nb
            if (x == 0) begin : g_l0
                assign left[r] = last_bit[r];
            end else begin : g_ln
                assign left[r] = rows[r][x-1];
            end
            if (x == MAX_WIDTH-1) begin : g_rl
                assign right[r] = first_bit[r];
            end else begin : g_rn
                assign right[r] = (int'(i_eff_width) == x + 1) ? first_bit[r]
                                                               : rows[r][x+1];
            end
        end

        assign count = 4'(left[0]) + 4'(i_up[x]) + 4'(right[0])
                     + 4'(left[1]) + 4'(right[1])
                     + 4'(left[2]) + 4'(i_down[x]) + 4'(right[2]);
        assign alive = (count == lce_pkg::BIRTH_COUNT)
                     | (i_mid[x] & (count == lce_pkg::SURVIVE_COUNT));

        // Columns beyond the board keep their value.
        assign o_next[x] = (int'(i_eff_width) > x) ? alive : i_mid[x];
    end

endmodule

### design/life_cellular_automaton_engine.sv
// Top level of the Game of Life engine: sequencer, row memory, config registers.
//
// Input channel (i_in_valid / o_in_ready) carries one operation per transfer: write
// cell, read cell, advance one generation, or clear the board. Every operation gives
// exactly one result transfer on the output channel (o_out_valid / i_out_ready);
// o_read_value holds the cell for a read and zero otherwise.
// The board is kept in one row-wide memory (MAX_HEIGHT rows of MAX_WIDTH cells).
// Read and write do one memory read; a write then writes back the modified row.
// Advance walks the rows once through the memory read port, updating a whole row
// a cycle from a three-row window. Clear zeroes the memory, one row a cycle.
// One operation is in flight at a time; a new one is taken while the previous
// result still waits at the output register.
// After reset the block sweeps the memory to zero and takes no input transfer
// meanwhile; APB writes are taken at any time.
// If the receiver stalls, a finished operation waits until the output register is
// free, and no new input is taken until then.
// The user must write configuration through the APB port only while the block
// is idle; the block itself does not enforce it.
module life_cellular_automaton_engine #(
    parameter int MAX_WIDTH  = lce_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = lce_pkg::MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_kind,
    input  logic [5:0]                  i_col,
    input  logic [5:0]                  i_row,
    input  logic                        i_cell_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_read_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lce_pkg::PADDR_W-1:0] paddr,
    input  logic [lce_pkg::PDATA_W-1:0] pwdata,
    output logic [lce_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH+1);
    localparam int EH = $clog2(MAX_HEIGHT+1);

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CELL  = 4'd2;
    localparam logic [3:0] ST_CLEAR = 4'd3;
    localparam logic [3:0] ST_PRE   = 4'd4;
    localparam logic [3:0] ST_LOAD0 = 4'd5;
    localparam logic [3:0] ST_LOAD1 = 4'd6;
    localparam logic [3:0] ST_RUN   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]                r_state, n_state;
    logic [AW-1:0]             r_idx, n_idx;
    logic [1:0]                r_kind;
    logic [5:0]                r_col;
    logic [5:0]                r_row;
    logic                      r_val;
    logic [MAX_WIDTH-1:0]      r_up, n_up;
    logic [MAX_WIDTH-1:0]      r_mid, n_mid;
    logic [MAX_WIDTH-1:0]      r_first, n_first;
    logic                      r_result, n_result;
    logic                      r_out_valid, n_out_valid;
    logic                      r_read_value, n_read_value;
    logic [lce_pkg::CFG_W-1:0] r_width;
    logic [lce_pkg::CFG_W-1:0] r_height;
    logic                      r_wrap;

    logic [EW-1:0]        eff_w;
    logic [EH-1:0]        eff_h;
    logic                 in_xfer;
    logic                 cfg_wr;
    logic                 on_board;
    logic [MAX_WIDTH-1:0] down_row;
    logic [MAX_WIDTH-1:0] next_row;
    logic [MAX_WIDTH-1:0] cell_row;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [MAX_WIDTH-1:0] ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;
    logic [MAX_WIDTH-1:0] ram_rd_data;

    // Board size in use, clamped to the storage limits.
    always_comb begin
        if (r_width == '0) begin
            eff_w = EW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(r_width);
        end
        if (r_height == '0) begin
            eff_h = EH'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            eff_h = EH'(MAX_HEIGHT);
        end else begin
            eff_h = EH'(r_height);
        end
    end

    // APB register port: always ready, writes land on the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        case (paddr[lce_pkg::PADDR_W-1:2])
            lce_pkg::REG_WIDTH:  prdata = lce_pkg::PDATA_W'(r_width);
            lce_pkg::REG_HEIGHT: prdata = lce_pkg::PDATA_W'(r_height);
            lce_pkg::REG_WRAP:   prdata = lce_pkg::PDATA_W'(r_wrap);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lce_pkg::CFG_W'(64);
            r_height <= lce_pkg::CFG_W'(64);
            r_wrap   <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[lce_pkg::PADDR_W-1:2])
                lce_pkg::REG_WIDTH:  r_width  <= pwdata[lce_pkg::CFG_W-1:0];
                lce_pkg::REG_HEIGHT: r_height <= pwdata[lce_pkg::CFG_W-1:0];
                lce_pkg::REG_WRAP:   r_wrap   <= pwdata[0];
                default:             ;
            endcase
        end
    end

    // Handshake and cell-operation helpers.
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid & o_in_ready;
    assign on_board   = (int'(r_col) < int'(eff_w)) && (int'(r_row) < int'(eff_h));

    // Row below the current one during a generation step.
    always_comb begin
        if (int'(r_idx) + 1 < int'(eff_h)) begin
            down_row = ram_rd_data;
        end else if (r_wrap) begin
            down_row = r_first;
        end else begin
            down_row = '0;
        end
    end

    // Row with the addressed cell replaced, for a write.
    always_comb begin
        cell_row = ram_rd_data;
        cell_row[CW'(r_col)] = r_val;
    end

    lce_row_rule #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_rule (
        .i_up        (r_up),
        .i_mid       (r_mid),
        .i_down      (down_row),
        .i_eff_width (eff_w),
        .i_wrap      (r_wrap),
        .o_next      (next_row)
    );

    lce_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_board (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Sequencer: memory addressing, write-back and next-state logic.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_up         = r_up;
        n_mid        = r_mid;
        n_first      = r_first;
        n_result     = r_result;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_read_value = r_read_value;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_idx;
        ram_wr_data  = '0;
        ram_rd_addr  = AW'(i_row);
        case (r_state)
            ST_INIT, ST_CLEAR: begin
                ram_wr_en = 1'b1;
                n_idx     = r_idx + AW'(1);
                if (int'(r_idx) == MAX_HEIGHT - 1) begin
                    n_idx    = '0;
                    n_result = 1'b0;
                    n_state  = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_idx = '0;
                    case (i_kind)
                        lce_pkg::KIND_WRITE, lce_pkg::KIND_READ: n_state = ST_CELL;
                        lce_pkg::KIND_STEP:                      n_state = ST_PRE;
                        default:                                 n_state = ST_CLEAR;
                    endcase
                end
            end
            ST_CELL: begin
                ram_wr_addr = AW'(r_row);
                ram_wr_data = cell_row;
                ram_wr_en   = on_board && (r_kind == lce_pkg::KIND_WRITE);
                n_result    = on_board && (r_kind == lce_pkg::KIND_READ)
                              && ram_rd_data[CW'(r_col)];
                n_state     = ST_DONE;
            end
            ST_PRE: begin
                ram_rd_addr = AW'(eff_h - EH'(1));
                n_state     = ST_LOAD0;
            end
            ST_LOAD0: begin
                n_up        = r_wrap ? ram_rd_data : '0;
                ram_rd_addr = '0;
                n_state     = ST_LOAD1;
            end
            ST_LOAD1: begin
                n_mid       = ram_rd_data;
                n_first     = ram_rd_data;
                ram_rd_addr = AW'(1);
                n_idx       = '0;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = next_row;
                ram_rd_addr = r_idx + AW'(2);
                n_up        = r_mid;
                n_mid       = down_row;
                n_idx       = r_idx + AW'(1);
                if (int'(r_idx) == int'(eff_h) - 1) begin
                    n_result = 1'b0;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_read_value = r_result;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= i_kind;
            r_col  <= i_col;
            r_row  <= i_row;
            r_val  <= i_cell_value;
        end
        r_up         <= n_up;
        r_mid        <= n_mid;
        r_first      <= n_first;
        r_result     <= n_result;
        r_read_value <= n_read_value;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;

`ifndef SYNTHESIS
    // Only one operation is in flight: a transfer closes the input until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("input accepted while an operation is in flight");

    // No result appears while the power-up sweep is running.
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !o_out_valid)
        else $error("result presented during memory initialization");

    // A generation step never writes a row beyond the board height.
    a_step_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && (r_state == ST_RUN)) |-> (int'(r_idx) < int'(eff_h)))
        else $error("generation step wrote outside the board");

    // A write leaves the result zero; only an in-board read can make it nonzero.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CELL) && (r_kind == lce_pkg::KIND_WRITE)) |=> !r_result)
        else $error("write produced a nonzero read value");
`endif

endmodule

### bench/life_cellular_automaton_engine_tb.sv
// Testbench for the Game of Life engine: directed and random operations checked against a board model.
`timescale 1ns / 1ps

module life_cellular_automaton_engine_tb;

    localparam int BW = 64;
    localparam int BH = 64;
    localparam int HOLD_OFF_CYCLES = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_kind;
    logic [5:0]        i_col;
    logic [5:0]        i_row;
    logic              i_cell_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_read_value;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [lce_pkg::PADDR_W-1:0] paddr;
    logic [lce_pkg::PDATA_W-1:0] pwdata;
    logic [lce_pkg::PDATA_W-1:0] prdata;
    logic              pready;

    // Board model and its configuration.
    logic        board [BH][BW];
    logic        fresh [BH][BW];
    int unsigned cols_cfg;
    int unsigned rows_cfg;
    logic        wrap_cfg;

    logic        read_values_due [$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_off_start = 1'b0;
    logic        hold_off;

    life_cellular_automaton_engine uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Long receiver hold-off, counted here once the test asks for it.
    initial begin
        hold_off = 1'b0;
        wait (hold_off_start);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic int unsigned used_cols();
        if (cols_cfg == 0) return 1;
        if (cols_cfg > BW) return BW;
        return cols_cfg;
    endfunction

    function automatic int unsigned used_rows();
        if (rows_cfg == 0) return 1;
        if (rows_cfg > BH) return BH;
        return rows_cfg;
    endfunction

    // One generation of rule B3/S23 over the used part of the board.
    function automatic void advance_board();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int nx;
        int ny;
        w = used_cols();
        h = used_rows();
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                n = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if (dx == 0 && dy == 0) continue;
                        if (wrap_cfg) begin
                            nx = (x + w + dx) % w;
                            ny = (y + h + dy) % h;
                        end else begin
                            nx = x + dx;
                            ny = y + dy;
                            if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
                        end
                        n += board[ny][nx];
                    end
                end
                fresh[y][x] = board[y][x] ? (n == 2 || n == 3) : (n == 3);
            end
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                board[y][x] = fresh[y][x];
    endfunction

    // Applies one operation to the model and returns its read value.
    function automatic logic apply_operation(logic [1:0] kind, logic [5:0] col,
                                             logic [5:0] row, logic value);
        logic on_board;
        on_board = (col < used_cols()) && (row < used_rows());
        case (kind)
            lce_pkg::KIND_WRITE: begin
                if (on_board) board[row][col] = value;
            end
            lce_pkg::KIND_READ: begin
                if (on_board) return board[row][col];
            end
            lce_pkg::KIND_STEP: begin
                advance_board();
            end
            default: begin
                foreach (board[y, x]) board[y][x] = 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // Sends one operation and records the expected read value.
    task automatic send_operation(logic [1:0] kind, logic [5:0] col, logic [5:0] row,
                                  logic value);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_col        <= col;
        i_row        <= row;
        i_cell_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        read_values_due.push_back(apply_operation(kind, col, row, value));
    endtask

    // Waits until every result has arrived and the block has settled.
    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (read_values_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (BH + 10) @(posedge i_clk);
    endtask

    // APB register write, setup then access cycle; the caller closes the bus.
    task automatic write_register(logic [1:0] index, logic [lce_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lce_pkg::PADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (index)
            lce_pkg::REG_WIDTH:  cols_cfg = value[6:0];
            lce_pkg::REG_HEIGHT: rows_cfg = value[6:0];
            default:             wrap_cfg = value[0];
        endcase
    endtask

    task automatic set_board(int unsigned w, int unsigned h, logic wrap);
        drain();
        write_register(lce_pkg::REG_WIDTH, w);
        write_register(lce_pkg::REG_HEIGHT, h);
        write_register(lce_pkg::REG_WRAP, {31'd0, wrap});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random(int count, int unsigned span_w, int unsigned span_h);
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_operation(lce_pkg::KIND_WRITE, 6'($urandom_range(span_w)),
                               6'($urandom_range(span_h)), 1'($urandom));
            else if (pick < 85)
                send_operation(lce_pkg::KIND_READ, 6'($urandom_range(span_w)),
                               6'($urandom_range(span_h)), 1'($urandom));
            else if (pick < 97)
                send_operation(lce_pkg::KIND_STEP, 6'($urandom), 6'($urandom),
                               1'($urandom));
            else
                send_operation(lce_pkg::KIND_CLEAR, 6'($urandom), 6'($urandom),
                               1'($urandom));
        end
    endtask

    // Blinker and corners, on the default board and with wrap.
    task automatic test_directed();
        send_operation(lce_pkg::KIND_WRITE, 6'd0, 6'd0, 1'b1);
        send_operation(lce_pkg::KIND_WRITE, 6'd63, 6'd63, 1'b1);
        send_operation(lce_pkg::KIND_READ, 6'd0, 6'd0, 1'b0);
        send_operation(lce_pkg::KIND_READ, 6'd63, 6'd63, 1'b0);
        send_operation(lce_pkg::KIND_WRITE, 6'd10, 6'd5, 1'b1);
        send_operation(lce_pkg::KIND_WRITE, 6'd11, 6'd5, 1'b1);
        send_operation(lce_pkg::KIND_WRITE, 6'd12, 6'd5, 1'b1);
        send_operation(lce_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
        send_operation(lce_pkg::KIND_READ, 6'd11, 6'd4, 1'b0);
        send_operation(lce_pkg::KIND_READ, 6'd11, 6'd6, 1'b0);
        send_operation(lce_pkg::KIND_READ, 6'd10, 6'd5, 1'b0);
        send_operation(lce_pkg::KIND_WRITE, 6'd0, 6'd0, 1'b0);
        send_operation(lce_pkg::KIND_CLEAR, 6'd0, 6'd0, 1'b0);
        send_operation(lce_pkg::KIND_READ, 6'd11, 6'd5, 1'b0);
        set_board(5, 4, 1'b1);
        send_operation(lce_pkg::KIND_WRITE, 6'd0, 6'd0, 1'b1);
        send_operation(lce_pkg::KIND_WRITE, 6'd4, 6'd0, 1'b1);
        send_operation(lce_pkg::KIND_WRITE, 6'd0, 6'd3, 1'b1);
        send_operation(lce_pkg::KIND_WRITE, 6'd5, 6'd0, 1'b1);
        send_operation(lce_pkg::KIND_READ, 6'd5, 6'd0, 1'b0);
        send_operation(lce_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
        send_operation(lce_pkg::KIND_READ, 6'd4, 6'd3, 1'b0);
        send_operation(lce_pkg::KIND_READ, 6'd0, 6'd0, 1'b0);
    endtask

    // Degenerate and out-of-range sizes, wrapped and not.
    task automatic test_extreme_sizes();
        set_board(0, 0, 1'b1);
        send_random(6, 2, 2);
        set_board(2, 1, 1'b1);
        send_random(8, 3, 2);
        set_board(127, 100, 1'b0);
        send_random(8, 63, 63);
        set_board(3, 64, 1'b0);
        send_random(10, 5, 63);
    endtask

    // Random traffic over small boards under each idling phase.
    task automatic test_random_phases();
        int sends [4] = '{0, 46, 0, 37};
        int stalls [4] = '{0, 0, 46, 37};
        for (int p = 0; p < 4; p++) begin
            set_board($urandom_range(8, 1), $urandom_range(8, 1), 1'($urandom));
            send_idle_pct  = sends[p];
            recv_stall_pct = stalls[p];
            send_random(18, 9, 9);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off while operations keep coming.
    task automatic test_backpressure();
        set_board(6, 6, 1'b0);
        hold_off_start = 1'b1;
        send_random(12, 7, 7);
    endtask

    // Receiver side: stalls, and checks each result against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (read_values_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transfer, read_value %0b", o_read_value);
                end else if (read_values_due[0] !== o_read_value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("read_value mismatch: expected %0b, actual %0b",
                                 read_values_due[0], o_read_value);
                    void'(read_values_due.pop_front());
                end else begin
                    void'(read_values_due.pop_front());
                end
            end
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        cols_cfg = 64;
        rows_cfg = 64;
        wrap_cfg = 1'b0;
        foreach (board[y, x]) board[y][x] = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = lce_pkg::KIND_WRITE;
        i_col        = '0;
        i_row        = '0;
        i_cell_value = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_extreme_sizes();
        test_random_phases();
        test_backpressure();
        drain();

        if (mismatch_count == 0 && read_values_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
design/lce_pkg.sv
design/lce_ram.sv
design/lce_row_rule.sv
design/life_cellular_automaton_engine.sv
bench/life_cellular_automaton_engine_tb.sv
